>>> sv/jdq_pkg.sv
// jdq_pkg: shared types, field widths and codes for the job deque block
// used by the channel interfaces, the deque top level and its checker
package jdq_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int OWNER_BITS_DEF = 16;

  // fixed field widths of the command and result beats
  localparam int CMD_W    = 2;
  localparam int OWNER_W  = 16;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_SLOT  = 2'd3
  } status_e;

endpackage

>>> sv/jdq_if.sv
// jdq_in_if / jdq_out_if: valid/ready channels for command and result beats
// depends on jdq_pkg for field widths
interface jdq_in_if;
  logic                                valid;
  logic                                ready;
  logic [jdq_pkg::CMD_W-1:0]           cmd;
  logic [jdq_pkg::OWNER_W-1:0]         owner_id;
  logic signed [jdq_pkg::VALUE_W-1:0]  job_value;
  logic [jdq_pkg::SLOT_W-1:0]          job_slot;

  modport source (output valid, cmd, owner_id, job_value, job_slot, input ready);
  modport sink   (input valid, cmd, owner_id, job_value, job_slot, output ready);
endinterface

interface jdq_out_if;
  logic                                valid;
  logic                                ready;
  logic [jdq_pkg::STATUS_W-1:0]        status;
  logic [jdq_pkg::SLOT_W-1:0]          slot_out;
  logic signed [jdq_pkg::VALUE_W-1:0]  value_out;
  logic [jdq_pkg::COUNT_W-1:0]         entry_count;

  modport source (output valid, status, slot_out, value_out, entry_count, input ready);
  modport sink   (input valid, status, slot_out, value_out, entry_count, output ready);
endinterface

>>> sv/jdq_ram.sv
// jdq_ram: one write port, one read port slot table with registered read data
// no dependencies; contents are undefined until written
module jdq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/job_deque_with_owner_search.sv
// Job deque with owner search: a bounded queue of jobs held as a doubly linked
// list in a table of SLOTS slots. One command beat is taken at a time and gives
// one result beat. Insert and append scan the slot-used bits from slot 0, one
// slot per cycle, for the lowest free slot and then link it in. Find walks the
// list from the head through the link memory, one entry per cycle since each
// next link comes out of a registered read, and stops at the first owner match
// or at the end of the list. A full table, a free slot removed or a find on an
// empty queue answer straight from the decode step. The block is ready again
// once the result is loaded. A result beat waits in an output register, so the
// next command is taken while it stalls.
// Depends on jdq_pkg, jdq_if and jdq_ram.
module job_deque_with_owner_search #(
  parameter int SLOTS      = jdq_pkg::SLOTS_DEF,
  parameter int OWNER_BITS = jdq_pkg::OWNER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jdq_in_if.sink      in_i,
  jdq_out_if.source   out_o
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int OWN_W  = (OWNER_BITS < jdq_pkg::OWNER_W) ? OWNER_BITS : jdq_pkg::OWNER_W;
  localparam int SX_W   = ((IDX_W > jdq_pkg::SLOT_W) ? IDX_W : jdq_pkg::SLOT_W) + 1;
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(SLOTS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_LINK1  = 4'd3;
  localparam logic [3:0] S_LINK2  = 4'd4;
  localparam logic [3:0] S_REMOVE = 4'd5;
  localparam logic [3:0] S_FIND   = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  logic [3:0]                         state_q, state_d;
  logic [jdq_pkg::CMD_W-1:0]          cmd_q, cmd_d;
  logic [OWN_W-1:0]                   owner_q, owner_d;
  logic [jdq_pkg::VALUE_W-1:0]        value_q, value_d;
  logic [jdq_pkg::SLOT_W-1:0]         slot_q, slot_d;
  logic [IDX_W-1:0]                   head_q, head_d;
  logic [IDX_W-1:0]                   tail_q, tail_d;
  logic [CNT_W-1:0]                   count_q, count_d;
  logic [SLOTS-1:0]                   used_q, used_d;
  logic [IDX_W-1:0]                   cur_q, cur_d;
  logic [CNT_W-1:0]                   steps_q, steps_d;
  logic [jdq_pkg::STATUS_W-1:0]       res_status_q, res_status_d;
  logic [IDX_W-1:0]                   res_slot_q, res_slot_d;
  logic [jdq_pkg::VALUE_W-1:0]        res_value_q, res_value_d;

  logic                               out_valid_q, out_valid_d;
  logic [jdq_pkg::STATUS_W-1:0]       out_status_q, out_status_d;
  logic [jdq_pkg::SLOT_W-1:0]         out_slot_q, out_slot_d;
  logic [jdq_pkg::VALUE_W-1:0]        out_value_q, out_value_d;
  logic [jdq_pkg::COUNT_W-1:0]        out_count_q, out_count_d;

  logic                               in_beat;
  logic                               out_free;
  logic [SX_W-1:0]                    slot_x;
  logic                               slot_in_range;
  logic [IDX_W-1:0]                   rm_idx;
  logic [IDX_W-1:0]                   rd_addr;

  logic                               next_we, prev_we, owner_we, value_we;
  logic [IDX_W-1:0]                   next_waddr, prev_waddr;
  logic [LINK_W-1:0]                  next_wdata, prev_wdata;
  logic [LINK_W-1:0]                  next_rd, prev_rd;
  logic [OWN_W-1:0]                   owner_rd;
  logic [jdq_pkg::VALUE_W-1:0]        value_rd;

  logic                               p_ok, n_ok, nx_ok;
  logic [CNT_W-1:0]                   steps_nx;

  assign in_beat  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  assign slot_x        = SX_W'(slot_q);
  assign slot_in_range = (slot_x < SX_W'(SLOTS));
  assign rm_idx        = slot_x[IDX_W-1:0];

  assign p_ok     = (prev_rd < NO_LINK);
  assign n_ok     = (next_rd < NO_LINK);
  assign nx_ok    = n_ok;
  assign steps_nx = steps_q + CNT_W'(1);

  // one shared read address for all four tables
  always_comb begin
    case (state_q)
      S_DECODE: rd_addr = (cmd_q == jdq_pkg::CMD_FIND) ? head_q : rm_idx;
      S_FIND:   rd_addr = next_rd[IDX_W-1:0];
      default:  rd_addr = cur_q;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    owner_d      = owner_q;
    value_d      = value_q;
    slot_d       = slot_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    used_d       = used_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_value_d  = res_value_q;

    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_value_d  = out_value_q;
    out_count_d  = out_count_q;

    next_we    = 1'b0;
    prev_we    = 1'b0;
    owner_we   = 1'b0;
    value_we   = 1'b0;
    next_waddr = cur_q;
    prev_waddr = cur_q;
    next_wdata = NO_LINK;
    prev_wdata = NO_LINK;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          cmd_d   = in_i.cmd;
          owner_d = OWN_W'(in_i.owner_id);
          value_d = in_i.job_value;
          slot_d  = in_i.job_slot;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_d = jdq_pkg::ST_OK;
        res_slot_d   = '0;
        res_value_d  = '0;
        case (cmd_q)
          jdq_pkg::CMD_INSERT, jdq_pkg::CMD_APPEND: begin
            if (count_q == CNT_W'(SLOTS)) begin
              res_status_d = jdq_pkg::ST_FULL;
              state_d      = S_DONE;
            end else begin
              cur_d   = '0;
              state_d = S_SCAN;
            end
          end
          jdq_pkg::CMD_REMOVE: begin
            if (!slot_in_range || !used_q[rm_idx]) begin
              res_status_d = jdq_pkg::ST_BAD_SLOT;
              state_d      = S_DONE;
            end else begin
              cur_d   = rm_idx;
              state_d = S_REMOVE;
            end
          end
          default: begin
            if (count_q == '0) begin
              res_status_d = jdq_pkg::ST_NOT_FOUND;
              state_d      = S_DONE;
            end else begin
              cur_d   = head_q;
              steps_d = '0;
              state_d = S_FIND;
            end
          end
        endcase
      end

      // lowest free slot, one used bit per cycle
      S_SCAN: begin
        if (!used_q[cur_q]) begin
          state_d = S_LINK1;
        end else begin
          cur_d = cur_q + IDX_W'(1);
        end
      end

      S_LINK1: begin
        owner_we = 1'b1;
        value_we = 1'b1;
        next_we  = 1'b1;
        prev_we  = 1'b1;
        next_wdata = (cmd_q == jdq_pkg::CMD_APPEND || count_q == '0) ?
                     NO_LINK : LINK_W'(head_q);
        prev_wdata = (cmd_q == jdq_pkg::CMD_INSERT || count_q == '0) ?
                     NO_LINK : LINK_W'(tail_q);
        if (count_q == '0) begin
          head_d         = cur_q;
          tail_d         = cur_q;
          used_d[cur_q]  = 1'b1;
          count_d        = count_q + CNT_W'(1);
          res_slot_d     = cur_q;
          state_d        = S_DONE;
        end else begin
          state_d = S_LINK2;
        end
      end

      // back link of the old head or forward link of the old tail
      S_LINK2: begin
        if (cmd_q == jdq_pkg::CMD_INSERT) begin
          prev_we    = 1'b1;
          prev_waddr = head_q;
          prev_wdata = LINK_W'(cur_q);
          head_d     = cur_q;
        end else begin
          next_we    = 1'b1;
          next_waddr = tail_q;
          next_wdata = LINK_W'(cur_q);
          tail_d     = cur_q;
        end
        used_d[cur_q] = 1'b1;
        count_d       = count_q + CNT_W'(1);
        res_slot_d    = cur_q;
        state_d       = S_DONE;
      end

      // links of the removed slot are on the read port now
      S_REMOVE: begin
        if (p_ok) begin
          next_we    = 1'b1;
          next_waddr = prev_rd[IDX_W-1:0];
          next_wdata = next_rd;
        end else begin
          head_d = n_ok ? next_rd[IDX_W-1:0] : '0;
        end
        if (n_ok) begin
          prev_we    = 1'b1;
          prev_waddr = next_rd[IDX_W-1:0];
          prev_wdata = prev_rd;
        end else begin
          tail_d = p_ok ? prev_rd[IDX_W-1:0] : '0;
        end
        used_d[cur_q] = 1'b0;
        count_d       = count_q - CNT_W'(1);
        res_slot_d    = cur_q;
        res_value_d   = value_rd;
        state_d       = S_DONE;
      end

      S_FIND: begin
        if (used_q[cur_q] && owner_rd == owner_q) begin
          res_slot_d  = cur_q;
          res_value_d = value_rd;
          state_d     = S_DONE;
        end else if (steps_nx >= count_q || !nx_ok) begin
          res_status_d = jdq_pkg::ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          cur_d   = next_rd[IDX_W-1:0];
          steps_d = steps_nx;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = jdq_pkg::SLOT_W'(res_slot_q);
          out_value_d  = res_value_q;
          out_count_d  = jdq_pkg::COUNT_W'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    owner_q      <= owner_d;
    value_q      <= value_d;
    slot_q       <= slot_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_value_q  <= res_value_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_value_q  <= out_value_d;
    out_count_q  <= out_count_d;
  end

  jdq_ram #(.DEPTH(SLOTS), .WIDTH(LINK_W)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rd)
  );

  jdq_ram #(.DEPTH(SLOTS), .WIDTH(LINK_W)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rd)
  );

  jdq_ram #(.DEPTH(SLOTS), .WIDTH(OWN_W)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (owner_we),
    .waddr_i (cur_q),
    .wdata_i (owner_q),
    .raddr_i (rd_addr),
    .rdata_o (owner_rd)
  );

  jdq_ram #(.DEPTH(SLOTS), .WIDTH(jdq_pkg::VALUE_W)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (value_we),
    .waddr_i (cur_q),
    .wdata_i (value_q),
    .raddr_i (rd_addr),
    .rdata_o (value_rd)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.slot_out    = out_slot_q;
  assign out_o.value_out   = out_value_q;
  assign out_o.entry_count = out_count_q;

endmodule

>>> sv/jdq_checker.sv
// jdq_checker: port-level assertions for the job deque, bound to the top level
// depends on jdq_pkg and job_deque_with_owner_search
module jdq_checker #(
  parameter int SLOTS = jdq_pkg::SLOTS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [jdq_pkg::STATUS_W-1:0]       status_i,
  input logic [jdq_pkg::SLOT_W-1:0]         slot_out_i,
  input logic signed [jdq_pkg::VALUE_W-1:0] value_out_i,
  input logic [jdq_pkg::COUNT_W-1:0]        entry_count_i
);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(slot_out_i) && $stable(value_out_i) && $stable(entry_count_i))
    else $error("result beat changed while stalled");

  // one command at a time: busy right after a beat is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while busy");

  // failed commands report no slot and no payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != jdq_pkg::ST_OK |-> slot_out_i == '0 && value_out_i == '0)
    else $error("failed command with nonzero slot or value");

  // a full report only with the table full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == jdq_pkg::ST_FULL |->
      entry_count_i == jdq_pkg::COUNT_W'(SLOTS))
    else $error("table full reported with free slots");

endmodule

bind job_deque_with_owner_search jdq_checker #(.SLOTS(SLOTS)) u_jdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .slot_out_i    (out_o.slot_out),
  .value_out_i   (out_o.value_out),
  .entry_count_i (out_o.entry_count)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for job_deque_with_owner_search, one command beat in, one result out
// holds its own model of the slot table and linked list; depends on jdq_pkg, jdq_if and the rtl
module tb;

  localparam int SLOTS      = jdq_pkg::SLOTS_DEF;
  localparam int OWNER_BITS = jdq_pkg::OWNER_BITS_DEF;
  localparam logic [4:0] NO_LINK = 5'(SLOTS);
  localparam logic [jdq_pkg::OWNER_W-1:0] OWNER_MASK =
    {jdq_pkg::OWNER_W{1'b1}} >> (jdq_pkg::OWNER_W - OWNER_BITS);

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 23;
  localparam int QUIET_LO    = 330;
  localparam int QUIET_HI    = 450;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_LEN    = 400;
  localparam int TAIL_WAIT   = 40;

  typedef struct packed {
    jdq_pkg::cmd_e                  cmd;
    logic [jdq_pkg::OWNER_W-1:0]    owner;
    logic [jdq_pkg::VALUE_W-1:0]    value;
    logic [jdq_pkg::SLOT_W-1:0]     slot;
  } job_cmd_t;

  typedef struct packed {
    jdq_pkg::status_e               status;
    logic [jdq_pkg::SLOT_W-1:0]     slot;
    logic [jdq_pkg::VALUE_W-1:0]    value;
    logic [jdq_pkg::COUNT_W-1:0]    count;
  } job_result_t;

  typedef struct {
    logic [4:0]                               head;
    logic [4:0]                               tail;
    logic [jdq_pkg::COUNT_W-1:0]              count;
    logic [SLOTS-1:0]                         used;
    logic [SLOTS-1:0][4:0]                    nxt;
    logic [SLOTS-1:0][4:0]                    prv;
    logic [SLOTS-1:0][jdq_pkg::OWNER_W-1:0]   owner;
    logic [SLOTS-1:0][jdq_pkg::VALUE_W-1:0]   value;
  } deque_state_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  jdq_in_if  in_if ();
  jdq_out_if out_if ();

  job_deque_with_owner_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  deque_state_t  model_state;
  deque_state_t  gen_state;
  job_cmd_t      pending_cmds [$];
  job_result_t   expected_results [$];
  int            n_accepted = 0;
  int            n_checked  = 0;
  int            n_errors   = 0;
  int            cycle_count = 0;
  int            hold_left  = 0;
  bit            hold_done  = 1'b0;
  job_cmd_t      next_cmd;
  job_cmd_t      taken_cmd;
  job_result_t   got_result;
  job_result_t   want_result;

  function automatic void clear_deque(inout deque_state_t st);
    st.head  = '0;
    st.tail  = '0;
    st.count = '0;
    st.used  = '0;
    st.nxt   = '0;
    st.prv   = '0;
    st.owner = '0;
    st.value = '0;
  endfunction

  // applies one command to a deque state and returns the result beat it gives
  function automatic job_result_t deque_step(inout deque_state_t st, input job_cmd_t c);
    job_result_t r;
    logic [4:0]  s;
    logic [4:0]  p;
    logic [4:0]  n;
    logic [4:0]  cur;
    logic [jdq_pkg::OWNER_W-1:0] who;
    int          k;
    bit          hit;
    r   = '{status: jdq_pkg::ST_OK, slot: '0, value: '0, count: '0};
    who = c.owner & OWNER_MASK;
    case (c.cmd)
      jdq_pkg::CMD_INSERT, jdq_pkg::CMD_APPEND: begin
        s = NO_LINK;
        for (k = SLOTS - 1; k >= 0; k--)
          if (!st.used[k]) s = 5'(k);
        if (s == NO_LINK) begin
          r.status = jdq_pkg::ST_FULL;
        end else begin
          st.owner[s[3:0]] = who;
          st.value[s[3:0]] = c.value;
          if (c.cmd == jdq_pkg::CMD_INSERT) begin
            st.prv[s[3:0]] = NO_LINK;
            if (st.count == 0) begin
              st.nxt[s[3:0]] = NO_LINK;
              st.tail = s;
            end else begin
              st.nxt[s[3:0]] = st.head;
              st.prv[st.head[3:0]] = s;
            end
            st.head = s;
          end else begin
            st.nxt[s[3:0]] = NO_LINK;
            if (st.count == 0) begin
              st.prv[s[3:0]] = NO_LINK;
              st.head = s;
            end else begin
              st.prv[s[3:0]] = st.tail;
              st.nxt[st.tail[3:0]] = s;
            end
            st.tail = s;
          end
          st.used[s[3:0]] = 1'b1;
          st.count = st.count + 1'b1;
          r.slot = s[3:0];
        end
      end
      jdq_pkg::CMD_REMOVE: begin
        if (!st.used[c.slot]) begin
          r.status = jdq_pkg::ST_BAD_SLOT;
        end else begin
          p = st.prv[c.slot];
          n = st.nxt[c.slot];
          if (p != NO_LINK) st.nxt[p[3:0]] = n;
          else st.head = (n != NO_LINK) ? n : 5'd0;
          if (n != NO_LINK) st.prv[n[3:0]] = p;
          else st.tail = (p != NO_LINK) ? p : 5'd0;
          st.used[c.slot] = 1'b0;
          st.count = st.count - 1'b1;
          r.slot  = c.slot;
          r.value = st.value[c.slot];
        end
      end
      default: begin
        // walk from the head, first owner match wins
        cur = st.head;
        hit = 1'b0;
        for (k = 0; k < int'(st.count) && cur != NO_LINK && !hit; k++) begin
          if (st.used[cur[3:0]] && st.owner[cur[3:0]] == who) hit = 1'b1;
          else cur = st.nxt[cur[3:0]];
        end
        if (hit) begin
          r.slot  = cur[3:0];
          r.value = st.value[cur[3:0]];
        end else begin
          r.status = jdq_pkg::ST_NOT_FOUND;
        end
      end
    endcase
    r.count = st.count;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at result %0d: %s", n_checked, msg);
    n_errors++;
  endtask

  // the generator keeps its own copy of the table to aim removes and finds
  task automatic queue_cmd(input jdq_pkg::cmd_e c, input logic [jdq_pkg::OWNER_W-1:0] o,
                           input logic [jdq_pkg::VALUE_W-1:0] v,
                           input logic [jdq_pkg::SLOT_W-1:0] s);
    job_cmd_t    beat;
    beat = '{cmd: c, owner: o, value: v, slot: s};
    void'(deque_step(gen_state, beat));
    pending_cmds.push_back(beat);
  endtask

  function automatic logic [jdq_pkg::OWNER_W-1:0] pick_owner();
    if ($urandom_range(99) < 50)
      return jdq_pkg::OWNER_W'($urandom_range(3)) * 16'h5555;
    return jdq_pkg::OWNER_W'($urandom());
  endfunction

  task automatic queue_random(input int n);
    int  i;
    int  k;
    int  used_slots [$];
    bit  grow;
    int  roll;
    for (i = 0; i < n; i++) begin
      used_slots.delete();
      for (k = 0; k < SLOTS; k++)
        if (gen_state.used[k]) used_slots.push_back(k);
      // alternate fill and drain epochs so the table swings between empty and full
      grow = ((i / 60) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < 10) begin
        queue_cmd(jdq_pkg::CMD_FIND, pick_owner(), $urandom(), 4'($urandom()));
      end else if (roll < 30) begin
        if (used_slots.size() > 0)
          queue_cmd(jdq_pkg::CMD_FIND,
                    gen_state.owner[used_slots[$urandom_range(used_slots.size() - 1)]],
                    $urandom(), 4'($urandom()));
        else
          queue_cmd(jdq_pkg::CMD_FIND, pick_owner(), $urandom(), 4'($urandom()));
      end else if ($urandom_range(99) < (grow ? 75 : 25)) begin
        queue_cmd($urandom_range(1) ? jdq_pkg::CMD_APPEND : jdq_pkg::CMD_INSERT,
                  pick_owner(), $urandom(), 4'($urandom()));
      end else if (used_slots.size() > 0 && $urandom_range(99) < 85) begin
        queue_cmd(jdq_pkg::CMD_REMOVE, pick_owner(), $urandom(),
                  4'(used_slots[$urandom_range(used_slots.size() - 1)]));
      end else begin
        queue_cmd(jdq_pkg::CMD_REMOVE, pick_owner(), $urandom(), 4'($urandom()));
      end
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_if.valid || n_checked != n_accepted)
      @(negedge clk_i);
  endtask

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.cmd       <= '0;
      in_if.owner_id  <= '0;
      in_if.job_value <= '0;
      in_if.job_slot  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        taken_cmd = '{cmd: jdq_pkg::cmd_e'(in_if.cmd), owner: in_if.owner_id,
                      value: in_if.job_value, slot: in_if.job_slot};
        expected_results.push_back(deque_step(model_state, taken_cmd));
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_cmds.size() != 0 &&
            ((n_accepted >= QUIET_LO && n_accepted < QUIET_HI) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          next_cmd = pending_cmds.pop_front();
          in_if.valid     <= 1'b1;
          in_if.cmd       <= next_cmd.cmd;
          in_if.owner_id  <= next_cmd.owner;
          in_if.job_value <= next_cmd.value;
          in_if.job_slot  <= next_cmd.slot;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (n_checked == HOLD_AT && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_result = '{status: jdq_pkg::status_e'(out_if.status), slot: out_if.slot_out,
                       value: out_if.value_out, count: out_if.entry_count};
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.status != want_result.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      got_result.status, want_result.status));
          if (got_result.slot != want_result.slot)
            report_mismatch($sformatf("slot_out %0d, want %0d",
                                      got_result.slot, want_result.slot));
          if (got_result.value != want_result.value)
            report_mismatch($sformatf("value_out %h, want %h",
                                      got_result.value, want_result.value));
          if (got_result.count != want_result.count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      got_result.count, want_result.count));
        end
        n_checked++;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (n_checked >= QUIET_LO && n_checked < QUIET_HI) ||
                        ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    clear_deque(model_state);
    clear_deque(gen_state);
    rst_ni = 1'b0;

    // empty table corner cases and field extremes
    queue_cmd(jdq_pkg::CMD_FIND,   16'h0000, 32'h0000_0000, 4'd0);
    queue_cmd(jdq_pkg::CMD_REMOVE, 16'hffff, 32'hffff_ffff, 4'd0);
    queue_cmd(jdq_pkg::CMD_INSERT, 16'h0000, 32'h8000_0000, 4'd15);
    queue_cmd(jdq_pkg::CMD_APPEND, 16'hffff, 32'h7fff_ffff, 4'd0);
    queue_cmd(jdq_pkg::CMD_FIND,   16'hffff, 32'h0000_0000, 4'd0);
    queue_cmd(jdq_pkg::CMD_REMOVE, 16'h0000, 32'h0000_0000, 4'd0);
    queue_cmd(jdq_pkg::CMD_REMOVE, 16'h0000, 32'h0000_0000, 4'd1);
    // fill the table, then hit it while full
    for (k = 0; k < SLOTS; k++)
      queue_cmd(jdq_pkg::CMD_APPEND, jdq_pkg::OWNER_W'(k) * 16'h1111, $urandom(), 4'(k));
    queue_cmd(jdq_pkg::CMD_INSERT, 16'h1234, 32'hffff_ffff, 4'd0);
    queue_cmd(jdq_pkg::CMD_APPEND, 16'h4321, 32'h0000_0001, 4'd0);
    queue_cmd(jdq_pkg::CMD_FIND,   16'hffff, 32'h0000_0000, 4'd0);
    queue_cmd(jdq_pkg::CMD_FIND,   16'h0001, 32'h0000_0000, 4'd0);
    queue_cmd(jdq_pkg::CMD_REMOVE, 16'h0000, 32'h0000_0000, 4'd7);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    drain();
    @(negedge clk_i);
    queue_random(260);
    drain();
    @(negedge clk_i);
    queue_random(270);
    drain();
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/jdq_pkg.sv
sv/jdq_if.sv
sv/jdq_ram.sv
sv/job_deque_with_owner_search.sv
sv/jdq_checker.sv
verif/tb.sv
